@@ rtl/core/gear_shift_scheduler_assert.svh @@
// Assertion macros for the gear shift scheduler RTL.
`ifndef GEAR_SHIFT_SCHEDULER_ASSERT_SVH
`define GEAR_SHIFT_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gear shift scheduler assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gear shift scheduler assertion failed");
`else
`define GSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/gss_pkg.sv @@
// Shared types, codes and helpers of the gear shift scheduler.
`default_nettype none
package gss_pkg;

  localparam int unsigned PointW = 16;
  localparam int unsigned KW     = 22;
  localparam int unsigned MulBW  = 16;
  localparam int unsigned ProdW  = KW + MulBW;

  // register indexes on the configuration port
  localparam logic [2:0] REG_UP_LO     = 3'd0;
  localparam logic [2:0] REG_UP_HI     = 3'd1;
  localparam logic [2:0] REG_DN_LO     = 3'd2;
  localparam logic [2:0] REG_DN_HI     = 3'd3;
  localparam logic [2:0] REG_KD_GAIN   = 3'd4;
  localparam logic [2:0] REG_BRAKE_LVL = 3'd5;
  localparam logic [2:0] REG_MIN_HOLD  = 3'd6;
  localparam logic [2:0] REG_GEAR_CNT  = 3'd7;

  // result shift kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;
  localparam logic [1:0] KIND_SEED = 2'd3;

  typedef struct packed {
    logic [63:0] up_lo;
    logic [63:0] up_hi;
    logic [63:0] dn_lo;
    logic [63:0] dn_hi;
    logic [11:0] kd_gain;
    logic [8:0]  brake_lvl;
    logic [15:0] min_hold;
    logic [3:0]  top_gear;
  } gss_cfg_t;

  typedef struct packed {
    logic             en;
    logic [KW-1:0]    a;
    logic [MulBW-1:0] b;
  } gss_mul_req_t;

  // Pick threshold field idx out of the low and high register pair.
  function automatic logic [PointW-1:0] point_of(input logic [63:0] lo,
                                                 input logic [63:0] hi,
                                                 input logic [2:0]  idx);
    logic [PointW-1:0] p;
    unique case (idx)
      3'd0:    p = lo[15:0];
      3'd1:    p = lo[31:16];
      3'd2:    p = lo[47:32];
      3'd3:    p = lo[63:48];
      3'd4:    p = hi[15:0];
      3'd5:    p = hi[31:16];
      3'd6:    p = hi[47:32];
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/gss_cfg_regs.sv @@
// Configuration register file with gear count clamping.
`default_nettype none
module gss_cfg_regs #(
  parameter int unsigned MAX_GEARS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i,
  output gss_pkg::gss_cfg_t      cfg_o
);
  import gss_pkg::*;

  logic [63:0] up_lo_q, up_hi_q, dn_lo_q, dn_hi_q;
  logic [11:0] kd_gain_q;
  logic [8:0]  brake_lvl_q;
  logic [15:0] min_hold_q;
  logic [3:0]  gear_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_lo_q     <= '0;
      up_hi_q     <= '0;
      dn_lo_q     <= '0;
      dn_hi_q     <= '0;
      kd_gain_q   <= '0;
      brake_lvl_q <= 9'd128;
      min_hold_q  <= 16'd1000;
      gear_cnt_q  <= 4'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UP_LO:     up_lo_q     <= cfg_data_i;
        REG_UP_HI:     up_hi_q     <= cfg_data_i;
        REG_DN_LO:     dn_lo_q     <= cfg_data_i;
        REG_DN_HI:     dn_hi_q     <= cfg_data_i;
        REG_KD_GAIN:   kd_gain_q   <= cfg_data_i[11:0];
        REG_BRAKE_LVL: brake_lvl_q <= cfg_data_i[8:0];
        REG_MIN_HOLD:  min_hold_q  <= cfg_data_i[15:0];
        REG_GEAR_CNT:  gear_cnt_q  <= cfg_data_i[3:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    cfg_o.up_lo     = up_lo_q;
    cfg_o.up_hi     = up_hi_q;
    cfg_o.dn_lo     = dn_lo_q;
    cfg_o.dn_hi     = dn_hi_q;
    cfg_o.kd_gain   = kd_gain_q;
    cfg_o.brake_lvl = brake_lvl_q;
    cfg_o.min_hold  = min_hold_q;
    // clamp gear count into 1..MAX_GEARS
    priority if (gear_cnt_q == 4'd0) begin
      cfg_o.top_gear = 4'd1;
    end else if (gear_cnt_q > 4'(MAX_GEARS)) begin
      cfg_o.top_gear = 4'(MAX_GEARS);
    end else begin
      cfg_o.top_gear = gear_cnt_q;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gss_mul_unit.sv @@
// Shared multiplier with registered product.
`default_nettype none
module gss_mul_unit (
  input  wire logic                  clk_i,
  input  wire gss_pkg::gss_mul_req_t req_i,
  output logic [gss_pkg::ProdW-1:0]  prod_o
);
  import gss_pkg::*;

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= ProdW'(req_i.a) * ProdW'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ rtl/core/gss_ctrl.sv @@
// Shift sequencer: seeding scan, hold timer, threshold tests and result register.
`default_nettype none
`include "gear_shift_scheduler_assert.svh"
module gss_ctrl #(
  parameter int unsigned MAX_GEARS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire gss_pkg::gss_cfg_t     cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [15:0]           speed_kmh_i,
  input  wire logic [8:0]            throttle_i,
  input  wire logic [8:0]            brake_i,
  input  wire logic [9:0]            elapsed_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [3:0]                 gear_o,
  output logic [1:0]                 shift_kind_o,
  output logic                       holding_o,
  output gss_pkg::gss_mul_req_t      mul_req_o,
  input  wire logic [gss_pkg::ProdW-1:0] prod_i
);
  import gss_pkg::*;

  localparam int unsigned IW      = $clog2(MAX_GEARS);
  localparam int unsigned NThresh = MAX_GEARS - 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_KSUM = 3'd3;
  localparam logic [2:0] ST_UP   = 3'd4;
  localparam logic [2:0] ST_UPC  = 3'd5;
  localparam logic [2:0] ST_DNC  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [3:0]    cur_gear_q, cur_gear_d;
  logic [15:0]   hold_q, hold_d;
  logic          seeded_q, seeded_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [3:0]    g_q, g_d;
  logic [1:0]    kind_q, kind_d;
  logic          hold_flag_q, hold_flag_d;
  logic [KW-1:0] k_q, k_d;
  logic [15:0]   speed_q;
  logic [8:0]    throttle_q, brake_q;
  logic [9:0]    elapsed_q;
  logic          out_valid_q, out_valid_d;
  logic [3:0]    out_gear_q;
  logic [1:0]    out_kind_q;
  logic          out_hold_q;
  logic          out_load;

  logic              in_acc;
  logic [31:0]       sp;
  logic [16:0]       seed_sum, seed_lhs;
  logic [3:0]        seed_cand, g_clamp;
  logic [15:0]       hold_dec;
  logic              up_ok, dn_ok, up_hit, dn_hit;
  logic [ProdW+2:0]  dn_lhs, dn_rhs;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sp         = {speed_q, 16'b0};

  // shared compare for the seeding scan
  assign seed_sum = 17'(point_of(cfg_i.up_lo, cfg_i.up_hi, 3'(idx_q)))
                  + 17'(point_of(cfg_i.dn_lo, cfg_i.dn_hi, 3'(idx_q)));
  assign seed_lhs = {speed_q, 1'b0};

  assign hold_dec = (hold_q > 16'(elapsed_q)) ? (hold_q - 16'(elapsed_q)) : 16'd0;
  assign up_ok    = (g_q < cfg_i.top_gear);
  assign dn_ok    = (g_q >= 4'd2);
  assign up_hit   = up_ok && ({6'b0, sp} > prod_i);
  assign dn_lhs   = (cfg_i.brake_lvl < brake_q) ? ((ProdW+3)'(sp) * (ProdW+3)'(5))
                                                : (ProdW+3)'(sp);
  assign dn_rhs   = (cfg_i.brake_lvl < brake_q) ? ((ProdW+3)'(prod_i) * (ProdW+3)'(6))
                                                : (ProdW+3)'(prod_i);
  assign dn_hit   = dn_lhs < dn_rhs;

  always_comb begin
    g_clamp = (cur_gear_q == 4'd0) ? 4'd1 : cur_gear_q;
    if (g_clamp > cfg_i.top_gear) begin
      g_clamp = cfg_i.top_gear;
    end
  end

  always_comb begin
    seed_cand = (seed_lhs >= seed_sum) ? (4'(idx_q) + 4'd2) : g_q;
  end

  always_comb begin
    state_d     = state_q;
    cur_gear_d  = cur_gear_q;
    hold_d      = hold_q;
    seeded_d    = seeded_q;
    idx_d       = idx_q;
    g_d         = g_q;
    kind_d      = kind_q;
    hold_flag_d = hold_flag_q;
    k_d         = k_q;
    out_load    = 1'b0;
    mul_req_o   = '0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d       = '0;
          g_d         = 4'd1;
          kind_d      = KIND_NONE;
          hold_flag_d = 1'b0;
          state_d     = seeded_q ? ST_CHK : ST_SEED;
        end
      end
      ST_SEED: begin
        idx_d = idx_q + IW'(1);
        g_d   = seed_cand;
        if (idx_q == IW'(NThresh - 1)) begin
          g_d        = (seed_cand > cfg_i.top_gear) ? cfg_i.top_gear : seed_cand;
          cur_gear_d = g_d;
          hold_d     = cfg_i.min_hold;
          seeded_d   = 1'b1;
          kind_d     = KIND_SEED;
          state_d    = ST_DONE;
        end
      end
      ST_CHK: begin
        g_d    = g_clamp;
        hold_d = hold_dec;
        if (hold_dec != 16'd0) begin
          hold_flag_d = 1'b1;
          state_d     = ST_DONE;
        end else begin
          mul_req_o.en = 1'b1;
          mul_req_o.a  = KW'(throttle_q);
          mul_req_o.b  = MulBW'(cfg_i.kd_gain);
          state_d      = ST_KSUM;
        end
      end
      ST_KSUM: begin
        k_d     = KW'(22'd65536 + KW'(prod_i[20:0]));
        state_d = ST_UP;
      end
      ST_UP: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = k_q;
        mul_req_o.b  = point_of(cfg_i.up_lo, cfg_i.up_hi, 3'(g_q - 4'd1));
        state_d      = ST_UPC;
      end
      ST_UPC: begin
        if (up_hit) begin
          g_d        = g_q + 4'd1;
          cur_gear_d = g_q + 4'd1;
          hold_d     = cfg_i.min_hold;
          kind_d     = KIND_UP;
          state_d    = ST_DONE;
        end else if (dn_ok) begin
          mul_req_o.en = 1'b1;
          mul_req_o.a  = k_q;
          mul_req_o.b  = point_of(cfg_i.dn_lo, cfg_i.dn_hi, 3'(g_q - 4'd2));
          state_d      = ST_DNC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DNC: begin
        if (dn_hit) begin
          g_d        = g_q - 4'd1;
          cur_gear_d = g_q - 4'd1;
          hold_d     = cfg_i.min_hold;
          kind_d     = KIND_DOWN;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_gear_q  <= 4'd1;
      hold_q      <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_gear_q  <= cur_gear_d;
      hold_q      <= hold_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    g_q         <= g_d;
    kind_q      <= kind_d;
    hold_flag_q <= hold_flag_d;
    k_q         <= k_d;
    if (in_acc) begin
      speed_q    <= speed_kmh_i;
      throttle_q <= throttle_i;
      brake_q    <= brake_i;
      elapsed_q  <= elapsed_ms_i;
    end
    if (out_load) begin
      out_gear_q <= g_q;
      out_kind_q <= kind_q;
      out_hold_q <= hold_flag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gear_o       = out_gear_q;
  assign shift_kind_o = out_kind_q;
  assign holding_o    = out_hold_q;

  `GSS_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE)
  `GSS_ASSERT_NXT(a_seeded_sticks, clk_i, rst_ni, seeded_q, seeded_q)
  `GSS_ASSERT_IMP(a_hold_no_shift, clk_i, rst_ni, out_valid_q && out_hold_q, out_kind_q == KIND_NONE)
  `GSS_ASSERT_IMP(a_gear_range, clk_i, rst_ni, 1'b1,
                  (cur_gear_q != 4'd0) && (cur_gear_q <= 4'(MAX_GEARS)))

endmodule
`default_nettype wire

@@ rtl/core/gear_shift_scheduler.sv @@
// Top level of the automatic transmission shift scheduler.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request per control tick:
//   speed, throttle, brake and elapsed milliseconds. Output channel
//   (out_valid_o / out_stall_i) returns one result per request: gear, shift
//   kind (none, up, down, seeded) and whether the hold timer blocked shifting.
//   The block works on one request at a time; in_stall_o is high from the
//   cycle after acceptance until the result is loaded into the output register.
//   Steps per request, run by the sequencer with the shared multiplier:
//     first request after reset: seeding scan, one threshold per cycle,
//       then the seeded gear as result
//     request blocked by the hold timer: hold check, then result
//     full shift evaluation: kickdown product, upshift, downshift
//   A stalled result stays in the output register; the next request is
//   accepted meanwhile and waits in its final step until the register frees.
//   Reset loads the register defaults, gear 1, an idle hold timer and an
//   unseeded state. Write configuration only while idle.
`default_nettype none
module gear_shift_scheduler #(
  parameter int unsigned MAX_GEARS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] speed_kmh_i,
  input  wire logic [8:0]  throttle_i,
  input  wire logic [8:0]  brake_i,
  input  wire logic [9:0]  elapsed_ms_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       gear_o,
  output logic [1:0]       shift_kind_o,
  output logic             holding_o
);
  import gss_pkg::*;

  gss_cfg_t         cfg;
  gss_mul_req_t     mul_req;
  logic [ProdW-1:0] prod;

  // register file, gear count clamped here once
  gss_cfg_regs #(
    .MAX_GEARS (MAX_GEARS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // one multiplier for kickdown factor and both threshold products
  gss_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // sequencer owns gear, hold timer, seeded flag and the result register
  gss_ctrl #(
    .MAX_GEARS (MAX_GEARS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .speed_kmh_i  (speed_kmh_i),
    .throttle_i   (throttle_i),
    .brake_i      (brake_i),
    .elapsed_ms_i (elapsed_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .gear_o       (gear_o),
    .shift_kind_o (shift_kind_o),
    .holding_o    (holding_o),
    .mul_req_o    (mul_req),
    .prod_i       (prod)
  );

endmodule
`default_nettype wire
